// ===== design/airlight_histogram_percentile_assert.svh =====
// Assertion macros for the airlight histogram percentile block.
`ifndef AIRLIGHT_HISTOGRAM_PERCENTILE_ASSERT_SVH
`define AIRLIGHT_HISTOGRAM_PERCENTILE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and idle during reset.
`define AHP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("airlight_histogram_percentile: check failed");
// Next-cycle implication, sampled on clk and idle during reset.
`define AHP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("airlight_histogram_percentile: check failed");
`else
`define AHP_ASSERT_IMP(label, ante, cons)
`define AHP_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== design/ahp_pkg.sv =====
// Shared constants for the airlight histogram percentile block.
package ahp_pkg;

  localparam int BINS  = 256;
  localparam int LUMA_W = 8;
  localparam int CNT_W = 22;
  localparam int PCT_W = 16;
  localparam int RHS_W = PCT_W + CNT_W;

  localparam logic [CNT_W-1:0]  MAX_PIXELS = 22'd2097152;
  localparam logic [LUMA_W-1:0] AIR_MIN    = 8'd160;
  localparam logic [LUMA_W-1:0] AIR_MAX    = 8'd255;
  localparam logic [PCT_W-1:0]  PCT_MIN    = 16'd32768;
  localparam logic [PCT_W-1:0]  PCT_MAX    = 16'd65470;
  localparam logic [PCT_W-1:0]  PCT_RESET  = 16'd64881;

endpackage

// ===== design/ahp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ahp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/airlight_histogram_percentile.sv =====
// Airlight estimator: luma histogram in RAM, percentile scan at end of frame.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_luma[7:0], in_last_pixel
//  out      output     out_valid/out_stall  out_airlight[7:0]
//  cfg      input      cfg_valid/cfg_ready  cfg_percentile_q16[15:0]
//
// Pixels are taken one per cycle; each bin update is a read-modify-write with
// forwarding from the previous write when consecutive pixels hit the same bin.
// After the last pixel the input stalls through the drain, multiply, scan and done states; the bins are
// read one per cycle through the single RAM read port up to the first that qualifies.
// Reset is synchronous and active low; it clears the bin valid bits and count.
// A result still stalled at the output when the next scan ends holds the input longer.
`include "airlight_histogram_percentile_assert.svh"

module airlight_histogram_percentile (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ahp_pkg::LUMA_W-1:0]   in_luma,
  input  logic                         in_last_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ahp_pkg::LUMA_W-1:0]   out_airlight,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ahp_pkg::PCT_W-1:0]    cfg_percentile_q16
);

  typedef enum logic [2:0] {S_PIX, S_DRAIN, S_MUL, S_SCAN, S_DONE} state_t;

  state_t                        state_r;
  logic [ahp_pkg::PCT_W-1:0]     pct_r;
  logic [ahp_pkg::CNT_W-1:0]     total_r;
  logic [ahp_pkg::BINS-1:0]      bin_vld_r;

  logic                          p1_vld_r;
  logic [ahp_pkg::LUMA_W-1:0]    p1_addr_r;
  logic                          wr_vld_r;
  logic [ahp_pkg::LUMA_W-1:0]    wr_addr_r;
  logic [ahp_pkg::CNT_W-1:0]     wr_data_r;

  logic [ahp_pkg::LUMA_W:0]      scan_addr_r;
  logic                          sc_vld_r;
  logic                          sc_bvld_r;
  logic [ahp_pkg::LUMA_W-1:0]    sc_bin_r;
  logic [ahp_pkg::CNT_W-1:0]     cum_r;
  logic [ahp_pkg::RHS_W-1:0]     rhs_r;
  logic [ahp_pkg::LUMA_W-1:0]    res_r;

  logic                          out_valid_r;
  logic [ahp_pkg::LUMA_W-1:0]    out_airlight_r;

  logic                          in_acc;
  logic                          cnt_ok;
  logic                          scan_issue;
  logic [ahp_pkg::LUMA_W-1:0]    rd_addr;
  logic [ahp_pkg::CNT_W-1:0]     rd_data;
  logic [ahp_pkg::CNT_W-1:0]     old_cnt;
  logic [ahp_pkg::CNT_W-1:0]     new_cnt_nxt;
  logic [ahp_pkg::CNT_W-1:0]     bin_val;
  logic [ahp_pkg::CNT_W-1:0]     cum_nxt;
  logic                          hit;
  logic [ahp_pkg::PCT_W-1:0]     pct_sat;
  logic [ahp_pkg::CNT_W-1:0]     total_m1;
  logic                          out_free;

  assign in_stall  = (state_r != S_PIX);
  assign cfg_ready = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_airlight = out_airlight_r;

  assign in_acc     = in_valid && !in_stall;
  assign cnt_ok     = (total_r < ahp_pkg::MAX_PIXELS);
  assign scan_issue = (state_r == S_SCAN) && !scan_addr_r[ahp_pkg::LUMA_W];
  assign rd_addr    = (state_r == S_SCAN) ? scan_addr_r[ahp_pkg::LUMA_W-1:0] : in_luma;
  assign out_free   = !out_valid_r || !out_stall;

  ahp_ram #(
    .WIDTH (ahp_pkg::CNT_W),
    .DEPTH (ahp_pkg::BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (p1_vld_r),
    .wr_addr (p1_addr_r),
    .wr_data (new_cnt_nxt),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The RAM read lags one write behind, so a repeat of the same bin takes the
  // value just written; a bin not yet touched this frame reads as zero.
  always_comb begin
    if (wr_vld_r && (wr_addr_r == p1_addr_r)) begin
      old_cnt = wr_data_r;
    end else if (bin_vld_r[p1_addr_r]) begin
      old_cnt = rd_data;
    end else begin
      old_cnt = '0;
    end
    new_cnt_nxt = old_cnt + ahp_pkg::CNT_W'(1);
  end

  always_comb begin
    bin_val = sc_bvld_r ? rd_data : '0;
    cum_nxt = cum_r + bin_val;
    hit     = sc_vld_r && (cum_nxt != '0) &&
              ({cum_nxt - ahp_pkg::CNT_W'(1), {ahp_pkg::PCT_W{1'b0}}} >= rhs_r);
  end

  always_comb begin
    if (pct_r < ahp_pkg::PCT_MIN) begin
      pct_sat = ahp_pkg::PCT_MIN;
    end else if (pct_r > ahp_pkg::PCT_MAX) begin
      pct_sat = ahp_pkg::PCT_MAX;
    end else begin
      pct_sat = pct_r;
    end
    total_m1 = (total_r != '0) ? (total_r - ahp_pkg::CNT_W'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PIX;
      pct_r       <= ahp_pkg::PCT_RESET;
      total_r     <= '0;
      bin_vld_r   <= '0;
      p1_vld_r    <= 1'b0;
      wr_vld_r    <= 1'b0;
      sc_vld_r    <= 1'b0;
      scan_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pct_r <= cfg_percentile_q16;
      end

      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // Bin update, write half.
      wr_vld_r <= p1_vld_r;
      if (p1_vld_r) begin
        wr_addr_r            <= p1_addr_r;
        wr_data_r            <= new_cnt_nxt;
        bin_vld_r[p1_addr_r] <= 1'b1;
      end

      // Bin update, read half; pixels past the frame limit are dropped.
      p1_vld_r <= in_acc && cnt_ok;
      if (in_acc && cnt_ok) begin
        p1_addr_r <= in_luma;
        total_r   <= total_r + ahp_pkg::CNT_W'(1);
      end

      sc_vld_r <= scan_issue;
      if (scan_issue) begin
        sc_bin_r    <= scan_addr_r[ahp_pkg::LUMA_W-1:0];
        sc_bvld_r   <= bin_vld_r[scan_addr_r[ahp_pkg::LUMA_W-1:0]];
        scan_addr_r <= scan_addr_r + 1'b1;
      end

      unique case (state_r)
        S_PIX: begin
          if (in_acc && in_last_pixel) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          rhs_r       <= ahp_pkg::RHS_W'(pct_sat) * ahp_pkg::RHS_W'(total_m1);
          cum_r       <= '0;
          scan_addr_r <= '0;
          state_r     <= S_SCAN;
        end
        S_SCAN: begin
          if (sc_vld_r) begin
            cum_r <= cum_nxt;
          end
          if (hit) begin
            res_r   <= (sc_bin_r < ahp_pkg::AIR_MIN) ? ahp_pkg::AIR_MIN : sc_bin_r;
            state_r <= S_DONE;
          end else if (sc_vld_r && (sc_bin_r == ahp_pkg::AIR_MAX)) begin
            res_r   <= ahp_pkg::AIR_MAX;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_airlight_r <= res_r;
            total_r        <= '0;
            bin_vld_r      <= '0;
            state_r        <= S_PIX;
          end
        end
        default: begin
          state_r <= S_PIX;
        end
      endcase
    end
  end

  `AHP_ASSERT_IMP(a_air_range, out_valid, out_airlight >= ahp_pkg::AIR_MIN)
  `AHP_ASSERT_NXT(a_last_stalls, in_valid && !in_stall && in_last_pixel, in_stall)
  `AHP_ASSERT_IMP(a_cum_bounded, sc_vld_r && (state_r == S_SCAN), cum_nxt <= total_r)
  `AHP_ASSERT_IMP(a_wr_in_frame, p1_vld_r, (state_r == S_PIX) || (state_r == S_DRAIN))

endmodule
